// ===== design/dau_pkg.sv =====
// Package for the decimal arithmetic unit: types, codes and the power-of-ten table.
package dau_pkg;

  localparam int MaxScaleStepDefault = 18;

  typedef enum logic [1:0] {
    OP_DIV = 2'd0,
    OP_MUL = 2'd1,
    OP_RESCALE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_INEXACT = 2'd2,
    ST_STEP_BIG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RM_UP = 3'd0,
    RM_DOWN = 3'd1,
    RM_CEIL = 3'd2,
    RM_FLOOR = 3'd3,
    RM_HALF_UP = 3'd4,
    RM_HALF_DOWN = 3'd5,
    RM_HALF_EVEN = 3'd6,
    RM_UNNEC = 3'd7
  } round_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DIV_END,
    S_DIGIT,
    S_DIGIT_END,
    S_RND_START,
    S_RND,
    S_RND_END,
    S_UP,
    S_DONE
  } state_t;

  // Command to and status from the shared radix-2 divider.
  // The dividend may carry a few bits above 64; they must be below the divisor.
  typedef struct packed {
    logic        start;
    logic [3:0]  dividend_hi;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_sts_t;

  function automatic logic [63:0] pow10(input logic [4:0] d);
    logic [63:0] p;
    p = 64'd1;
    unique case (d)
      5'd1: p = 64'd10;
      5'd2: p = 64'd100;
      5'd3: p = 64'd1000;
      5'd4: p = 64'd10000;
      5'd5: p = 64'd100000;
      5'd6: p = 64'd1000000;
      5'd7: p = 64'd10000000;
      5'd8: p = 64'd100000000;
      5'd9: p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== design/dau_divider.sv =====
// Shared unsigned 64-bit restoring divider, one quotient bit per cycle.
module dau_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  dau_pkg::div_cmd_t cmd,
  output dau_pkg::div_sts_t sts
);

  logic [63:0] quo_r, quo_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  // One shift-subtract step per cycle.
  always_comb begin
    shifted  = {rem_r[63:0], quo_r[63]};
    diff     = shifted - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      // The bits above 64 start the partial remainder.
      quo_nxt  = cmd.dividend;
      rem_nxt  = {61'd0, cmd.dividend_hi};
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (cmd.start) begin
      dvs_r <= cmd.divisor;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.quo  = quo_r;
  assign sts.rem  = rem_r[63:0];

endmodule

// ===== design/decimal_arith_unit.sv =====
// Top level of the scaled-decimal arithmetic unit: sequencer, datapath and output register.
// One request is taken at a time; in_stall stays high from acceptance until the result has
// moved into the output register, so a new request may start while that result waits.
// Unknown operations go from idle straight to the done state, multiply through S_MUL first; the
// done state waits until the output register is free. Divide runs the magnitude division on the
// shared restoring divider, then one divider pass (dividend ten times the remainder) per extra
// decimal digit, up to MAX_SCALE_STEP (eighteen by default) digit steps; when the scale comes
// down instead, a rounding pass follows. Rescale downward takes one divider pass; rescale
// upward multiplies by ten once per step.
module decimal_arith_unit #(
  parameter int MAX_SCALE_STEP = dau_pkg::MaxScaleStepDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [63:0] in_sig_a,
  input  logic signed [7:0]  in_scale_a,
  input  logic signed [63:0] in_sig_b,
  input  logic signed [7:0]  in_scale_b,
  input  logic signed [7:0]  in_target_scale,
  input  logic [2:0]         in_round_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_result_sig,
  output logic signed [8:0]  out_result_scale,
  output logic [1:0]         out_status
);

  dau_pkg::state_t state_r, state_nxt;
  dau_pkg::div_cmd_t dcmd;
  dau_pkg::div_sts_t dsts;

  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] mb_r, mb_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic signed [8:0] rs_r, rs_nxt;
  logic signed [7:0] ts_r, ts_nxt;
  logic [2:0] rm_r, rm_nxt;
  logic qneg_r, qneg_nxt;
  logic [4:0] steps_r, steps_nxt;
  logic [4:0] d_r, d_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [63:0] res_sig_r, res_sig_nxt;
  logic signed [8:0] res_scale_r, res_scale_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic [63:0] out_sig_r, out_sig_nxt;
  logic signed [8:0] out_scale_r, out_scale_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  logic signed [9:0] diff_s;
  logic [9:0] diff_mag;
  logic [63:0] ten_p, half, q_b, rmag;
  logic bump, val_neg;
  logic [63:0] dig;
  logic [67:0] ten_rem;

  localparam logic [9:0] StepMax = 10'(MAX_SCALE_STEP);

  dau_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (dcmd),
    .sts  (dsts)
  );

  // Scale difference between current scale and target.
  always_comb begin
    diff_s   = 10'(rs_r) - 10'(ts_r);
    diff_mag = diff_s[9] ? 10'(-diff_s) : 10'(diff_s);
  end

  // Ten times the remainder, kept at full width for the next digit.
  assign ten_rem = {1'b0, rem_r, 3'd0} + {3'd0, rem_r, 1'b0};

  // Rounding decision on the finished divider pass.
  always_comb begin
    ten_p   = dau_pkg::pow10(d_r);
    half    = ten_p >> 1;
    q_b     = dsts.quo;
    rmag    = dsts.rem;
    val_neg = acc_r[63];
    dig     = (dsts.quo[3:0] == 4'd0) ? 64'd0 : {60'd0, dsts.quo[3:0]};
    bump    = 1'b0;
    unique case (dau_pkg::round_t'(rm_r))
      dau_pkg::RM_UP:        bump = (rmag != 64'd0);
      dau_pkg::RM_DOWN:      bump = 1'b0;
      dau_pkg::RM_CEIL:      bump = !val_neg && (rmag != 64'd0);
      dau_pkg::RM_FLOOR:     bump = val_neg && (rmag != 64'd0);
      dau_pkg::RM_HALF_UP:   bump = (rmag >= half + {63'd0, ten_p[0]});
      dau_pkg::RM_HALF_DOWN: bump = (rmag > half);
      dau_pkg::RM_HALF_EVEN: bump = (rmag > half) || ((rmag == half) && q_b[0]);
      dau_pkg::RM_UNNEC:     bump = 1'b0;
      default:               bump = 1'b0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    a_nxt = a_r; b_nxt = b_r; mb_nxt = mb_r; rem_nxt = rem_r; acc_nxt = acc_r;
    rs_nxt = rs_r; ts_nxt = ts_r; rm_nxt = rm_r; qneg_nxt = qneg_r;
    steps_nxt = steps_r; d_nxt = d_r;
    out_valid_nxt  = out_valid_r;
    res_sig_nxt    = res_sig_r;
    res_scale_nxt  = res_scale_r;
    res_status_nxt = res_status_r;
    out_sig_nxt    = out_sig_r;
    out_scale_nxt  = out_scale_r;
    out_status_nxt = out_status_r;
    dcmd.start       = 1'b0;
    dcmd.dividend_hi = '0;
    dcmd.dividend    = '0;
    dcmd.divisor     = '0;
    in_stall       = (state_r != dau_pkg::S_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      dau_pkg::S_IDLE: begin
        if (in_valid) begin
          a_nxt  = in_sig_a;
          b_nxt  = in_sig_b;
          ts_nxt = in_target_scale;
          rm_nxt = in_round_mode;
          qneg_nxt = in_sig_a[63] ^ in_sig_b[63];
          mb_nxt = in_sig_b[63] ? 64'(-in_sig_b) : in_sig_b;
          unique case (dau_pkg::op_t'(in_mode))
            dau_pkg::OP_DIV: begin
              rs_nxt = 9'(in_scale_a) - 9'(in_scale_b);
              state_nxt = dau_pkg::S_DIV;
            end
            dau_pkg::OP_MUL: begin
              rs_nxt = 9'(in_scale_a) + 9'(in_scale_b);
              state_nxt = dau_pkg::S_MUL;
            end
            dau_pkg::OP_RESCALE: begin
              rs_nxt  = 9'(in_scale_a);
              acc_nxt = in_sig_a;
              state_nxt = dau_pkg::S_RND_START;
            end
            default: begin
              res_sig_nxt = '0; res_scale_nxt = '0;
              res_status_nxt = dau_pkg::ST_OK;
              state_nxt = dau_pkg::S_DONE;
            end
          endcase
        end
      end
      dau_pkg::S_MUL: begin
        // Wrapping 64-bit product split into 32-bit partial products.
        res_sig_nxt = {a_r[31:0] * b_r[63:32] + a_r[63:32] * b_r[31:0], 32'd0}
                      + {32'd0, a_r[31:0]} * {32'd0, b_r[31:0]};
        res_scale_nxt = rs_r;
        res_status_nxt = dau_pkg::ST_OK;
        state_nxt = dau_pkg::S_DONE;
      end
      dau_pkg::S_DIV: begin
        if (mb_r == 64'd0) begin
          res_sig_nxt = '0; res_scale_nxt = '0;
          res_status_nxt = dau_pkg::ST_DIV_ZERO;
          state_nxt = dau_pkg::S_DONE;
        end else begin
          dcmd.start = 1'b1;
          dcmd.dividend = a_r[63] ? 64'(-a_r) : a_r;
          dcmd.divisor = mb_r;
          state_nxt = dau_pkg::S_DIV_END;
        end
      end
      dau_pkg::S_DIV_END: begin
        if (dsts.done) begin
          acc_nxt = qneg_r ? 64'(-dsts.quo) : dsts.quo;
          rem_nxt = dsts.rem;
          if (diff_s < 0) begin
            if (diff_mag > StepMax) begin
              res_sig_nxt = qneg_r ? 64'(-dsts.quo) : dsts.quo;
              res_scale_nxt = rs_r;
              res_status_nxt = dau_pkg::ST_STEP_BIG;
              state_nxt = dau_pkg::S_DONE;
            end else begin
              steps_nxt = diff_mag[4:0];
              state_nxt = dau_pkg::S_DIGIT;
            end
          end else begin
            state_nxt = dau_pkg::S_RND_START;
          end
        end
      end
      dau_pkg::S_DIGIT: begin
        if (steps_r == 5'd0) begin
          res_sig_nxt = acc_r; res_scale_nxt = 9'(ts_r);
          res_status_nxt = dau_pkg::ST_OK;
          state_nxt = dau_pkg::S_DONE;
        end else begin
          // Ten times the remainder, below 10*mb, so the quotient is one digit.
          dcmd.start = 1'b1;
          dcmd.dividend_hi = ten_rem[67:64];
          dcmd.dividend = ten_rem[63:0];
          dcmd.divisor = mb_r;
          state_nxt = dau_pkg::S_DIGIT_END;
        end
      end
      dau_pkg::S_DIGIT_END: begin
        if (dsts.done) begin
          rem_nxt = dsts.rem;
          acc_nxt = {acc_r[60:0], 3'd0} + {acc_r[62:0], 1'b0}
                    + (qneg_r ? 64'(-dig) : dig);
          steps_nxt = steps_r - 5'd1;
          state_nxt = dau_pkg::S_DIGIT;
        end
      end
      dau_pkg::S_RND_START: begin
        // acc_r holds the value to round, rs_r its scale.
        if (diff_s == 0) begin
          res_sig_nxt = acc_r; res_scale_nxt = rs_r;
          res_status_nxt = dau_pkg::ST_OK;
          state_nxt = dau_pkg::S_DONE;
        end else if (diff_mag > StepMax) begin
          res_sig_nxt = acc_r; res_scale_nxt = rs_r;
          res_status_nxt = dau_pkg::ST_STEP_BIG;
          state_nxt = dau_pkg::S_DONE;
        end else if (diff_s < 0) begin
          steps_nxt = diff_mag[4:0];
          state_nxt = dau_pkg::S_UP;
        end else begin
          d_nxt = diff_mag[4:0];
          state_nxt = dau_pkg::S_RND;
        end
      end
      dau_pkg::S_RND: begin
        dcmd.start = 1'b1;
        dcmd.dividend = acc_r[63] ? 64'(-acc_r) : acc_r;
        dcmd.divisor = ten_p;
        state_nxt = dau_pkg::S_RND_END;
      end
      dau_pkg::S_RND_END: begin
        if (dsts.done) begin
          if ((dau_pkg::round_t'(rm_r) == dau_pkg::RM_UNNEC) && (dsts.rem != 64'd0)) begin
            res_sig_nxt = acc_r; res_scale_nxt = rs_r;
            res_status_nxt = dau_pkg::ST_INEXACT;
          end else begin
            res_sig_nxt = val_neg ? 64'(-(dsts.quo + {63'd0, bump}))
                                  : dsts.quo + {63'd0, bump};
            res_scale_nxt = 9'(ts_r);
            res_status_nxt = dau_pkg::ST_OK;
          end
          state_nxt = dau_pkg::S_DONE;
        end
      end
      dau_pkg::S_UP: begin
        if (steps_r == 5'd0) begin
          res_sig_nxt = acc_r; res_scale_nxt = 9'(ts_r);
          res_status_nxt = dau_pkg::ST_OK;
          state_nxt = dau_pkg::S_DONE;
        end else begin
          acc_nxt = {acc_r[60:0], 3'd0} + {acc_r[62:0], 1'b0};
          steps_nxt = steps_r - 5'd1;
        end
      end
      dau_pkg::S_DONE: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_sig_nxt    = res_sig_r;
          out_scale_nxt  = res_scale_r;
          out_status_nxt = res_status_r;
          state_nxt = dau_pkg::S_IDLE;
        end
      end
      default: state_nxt = dau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dau_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; mb_r <= mb_nxt; rem_r <= rem_nxt; acc_r <= acc_nxt;
    rs_r <= rs_nxt; ts_r <= ts_nxt; rm_r <= rm_nxt; qneg_r <= qneg_nxt;
    steps_r <= steps_nxt; d_r <= d_nxt;
    res_sig_r <= res_sig_nxt; res_scale_r <= res_scale_nxt; res_status_r <= res_status_nxt;
    out_sig_r <= out_sig_nxt; out_scale_r <= out_scale_nxt; out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_sig   = out_sig_r;
  assign out_result_scale = out_scale_r;
  assign out_status       = out_status_r;

endmodule
